FILE: rtl/sbsm_pkg.sv
// Shared types and constants for the serial bank switch mapper.
// No dependencies; every other RTL file except sbsm_if imports this package.
`default_nettype none

package sbsm_pkg;

  // Field widths of one bus access and one mapped result
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned TARGET_W = 3;
  localparam int unsigned OFFSET_W = 18;
  localparam int unsigned MIRROR_W = 2;

  // Configuration port
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 4;

  // Serial loader and bank registers
  localparam int unsigned LOAD_W  = 5;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned PRG_W   = 4;

  localparam logic [LOAD_W-1:0]  CTRL_RESET     = 5'h1C;
  localparam logic [LOAD_W-1:0]  CTRL_PRG_FORCE = 5'h0C;
  localparam logic [COUNT_W-1:0] LOAD_FULL      = 3'd5;

  // Configuration widths and reset values
  localparam int unsigned PRG_COUNT_W = 5;
  localparam int unsigned PRG_RAM_W   = 14;
  localparam int unsigned CHR_SIZE_W  = 18;

  localparam logic [PRG_COUNT_W-1:0] PRG_COUNT_RESET = 5'd16;
  localparam logic [PRG_RAM_W-1:0]   PRG_RAM_RESET   = 14'd8192;
  localparam logic [CHR_SIZE_W-1:0]  CHR_ROM_RESET   = 18'd0;
  localparam logic [CHR_SIZE_W-1:0]  CHR_RAM_RESET   = 18'd8192;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CPU_RD = 2'd0,
    ACT_CPU_WR = 2'd1,
    ACT_PPU_RD = 2'd2,
    ACT_PPU_WR = 2'd3
  } action_t;

  typedef enum logic [TARGET_W-1:0] {
    TGT_NONE    = 3'd0,
    TGT_PRG_RAM = 3'd1,
    TGT_PRG_ROM = 3'd2,
    TGT_CHR_ROM = 3'd3,
    TGT_CHR_RAM = 3'd4
  } target_t;

  typedef enum logic [1:0] {
    REG_PRG_COUNT = 2'd0,
    REG_PRG_RAM   = 2'd1,
    REG_CHR_ROM   = 2'd2,
    REG_CHR_RAM   = 2'd3
  } reg_idx_t;

  // Serial register select, from address bits 14..13
  typedef enum logic [1:0] {
    SEL_CONTROL  = 2'd0,
    SEL_CHR_LOW  = 2'd1,
    SEL_CHR_HIGH = 2'd2,
    SEL_PRG      = 2'd3
  } sel_t;

  typedef struct packed {
    logic [PRG_COUNT_W-1:0] prg_bank_count;
    logic [PRG_RAM_W-1:0]   prg_ram_size;
    logic [CHR_SIZE_W-1:0]  chr_rom_size;
    logic [CHR_SIZE_W-1:0]  chr_ram_size;
  } cfg_t;

  typedef struct packed {
    logic [LOAD_W-1:0] control;
    logic [LOAD_W-1:0] chr_low;
    logic [LOAD_W-1:0] chr_high;
    logic [PRG_W-1:0]  prg_page;
  } bank_state_t;

  typedef struct packed {
    target_t             target;
    logic [OFFSET_W-1:0] mem_offset;
    logic                mem_write;
    logic [DATA_W-1:0]   store_data;
  } map_result_t;

endpackage

`default_nettype wire

FILE: rtl/sbsm_if.sv
// Valid/ready channel interfaces for bus accesses and mapped results.
// Standalone; field widths follow the mapper's fixed item format.
`default_nettype none

interface sbsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] addr;
  logic [7:0]  write_data;

  modport source (output valid, action, addr, write_data, input ready);
  modport sink   (input valid, action, addr, write_data, output ready);
endinterface

interface sbsm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [17:0] mem_offset;
  logic        mem_write;
  logic [7:0]  store_data;
  logic [1:0]  mirroring;

  modport source (output valid, target, mem_offset, mem_write, store_data, mirroring,
                  input ready);
  modport sink   (input valid, target, mem_offset, mem_write, store_data, mirroring,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/sbsm_cfg.sv
// APB-style configuration registers: memory sizes and bank count.
// Depends on sbsm_pkg.
`default_nettype none

module sbsm_cfg
  import sbsm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_bank_count <= PRG_COUNT_RESET;
      cfg.prg_ram_size   <= PRG_RAM_RESET;
      cfg.chr_rom_size   <= CHR_ROM_RESET;
      cfg.chr_ram_size   <= CHR_RAM_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_PRG_COUNT: cfg.prg_bank_count <= pwdata[PRG_COUNT_W-1:0];
        REG_PRG_RAM:   cfg.prg_ram_size   <= pwdata[PRG_RAM_W-1:0];
        REG_CHR_ROM:   cfg.chr_rom_size   <= pwdata[CHR_SIZE_W-1:0];
        REG_CHR_RAM:   cfg.chr_ram_size   <= pwdata[CHR_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PRG_COUNT: prdata = {{(PDATA_W-PRG_COUNT_W){1'b0}}, cfg.prg_bank_count};
      REG_PRG_RAM:   prdata = {{(PDATA_W-PRG_RAM_W){1'b0}}, cfg.prg_ram_size};
      REG_CHR_ROM:   prdata = {{(PDATA_W-CHR_SIZE_W){1'b0}}, cfg.chr_rom_size};
      REG_CHR_RAM:   prdata = {{(PDATA_W-CHR_SIZE_W){1'b0}}, cfg.chr_ram_size};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/sbsm_serial.sv
// Serial loader: 5-bit shifter, write count, control and bank registers.
// Depends on sbsm_pkg.
`default_nettype none

module sbsm_serial
  import sbsm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              strobe,
  input  wire logic [1:0]        sel,
  input  wire logic [DATA_W-1:0] data,
  output bank_state_t            st,
  output logic [LOAD_W-1:0]      control_next
);

  logic [LOAD_W-1:0]  shift_load, shift_load_next, shifted;
  logic [COUNT_W-1:0] serial_count, serial_count_next, count_inc;
  bank_state_t        st_next;

  always_comb begin
    shifted           = {data[0], shift_load[LOAD_W-1:1]};
    count_inc         = serial_count + 3'd1;
    shift_load_next   = shift_load;
    serial_count_next = serial_count;
    st_next           = st;
    if (strobe) begin
      if (data[7]) begin
        // reset the loader and force the fixed-last-bank PRG mode
        shift_load_next   = '0;
        serial_count_next = '0;
        st_next.control   = st.control | CTRL_PRG_FORCE;
      end else if (count_inc == LOAD_FULL) begin
        shift_load_next   = '0;
        serial_count_next = '0;
        case (sel_t'(sel))
          SEL_CONTROL:  st_next.control  = shifted;
          SEL_CHR_LOW:  st_next.chr_low  = shifted;
          SEL_CHR_HIGH: st_next.chr_high = shifted;
          SEL_PRG:      st_next.prg_page = shifted[PRG_W-1:0];
          default: ;
        endcase
      end else begin
        shift_load_next   = shifted;
        serial_count_next = count_inc;
      end
    end
  end

  assign control_next = st_next.control;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_load   <= '0;
      serial_count <= '0;
      st.control   <= CTRL_RESET;
      st.chr_low   <= '0;
      st.chr_high  <= '0;
      st.prg_page  <= '0;
    end else begin
      shift_load   <= shift_load_next;
      serial_count <= serial_count_next;
      st           <= st_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    serial_count < LOAD_FULL)
    else $error("serial count passed the commit point");
  a_empty_shift: assert property (@(posedge clk) disable iff (rst)
    serial_count == '0 |-> shift_load == '0)
    else $error("shifter holds bits with no writes counted");
  a_reset_write: assert property (@(posedge clk) disable iff (rst)
    strobe && data[7] |=> serial_count == '0 && st.control[3:2] == 2'b11)
    else $error("reset write did not clear loader or force PRG mode");
`endif

endmodule

`default_nettype wire

FILE: rtl/sbsm_map.sv
// Address mapping: picks the target memory, bank-maps and masks the offset.
// Depends on sbsm_pkg; purely combinational.
`default_nettype none

module sbsm_map
  import sbsm_pkg::*;
(
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [ADDR_W-1:0]   addr,
  input  wire logic [DATA_W-1:0]   write_data,
  input  cfg_t                     cfg,
  input  bank_state_t              st,
  output map_result_t              res
);

  logic [PRG_COUNT_W-1:0] last;
  logic [PRG_COUNT_W-1:0] bank, bank_m;
  logic [PRG_RAM_W-1:0]   ram_mask;
  logic [CHR_SIZE_W-1:0]  chr_rom_mask, chr_ram_mask, chr_raw;
  logic                   top;
  logic                   in_prg_ram, in_chr;

  always_comb begin
    last         = cfg.prg_bank_count - 5'd1;
    top          = addr[14];
    ram_mask     = cfg.prg_ram_size - 14'd1;
    chr_rom_mask = cfg.chr_rom_size - 18'd1;
    chr_ram_mask = cfg.chr_ram_size - 18'd1;
    in_prg_ram   = addr[15:13] == 3'b011;
    in_chr       = addr[15:13] == 3'b000;

    case (st.control[3:2])
      2'b00, 2'b01: bank = {1'b0, st.prg_page[3:1], top};
      2'b10:        bank = top ? {1'b0, st.prg_page} : '0;
      default:      bank = top ? last : {1'b0, st.prg_page};
    endcase
    bank_m = bank & last;

    if (!st.control[4])
      chr_raw = {1'b0, st.chr_low[4:1], addr[12:0]};
    else if (!addr[12])
      chr_raw = {1'b0, st.chr_low, addr[11:0]};
    else
      chr_raw = {1'b0, st.chr_high, addr[11:0]};

    res = '{target: TGT_NONE, mem_offset: '0, mem_write: 1'b0, store_data: '0};
    case (action_t'(action))
      ACT_CPU_RD, ACT_CPU_WR: begin
        if (in_prg_ram) begin
          if (cfg.prg_ram_size != '0) begin
            res.target     = TGT_PRG_RAM;
            res.mem_offset = {4'd0, {1'b0, addr[12:0]} & ram_mask};
            res.mem_write  = action_t'(action) == ACT_CPU_WR;
          end
        end else if (addr[15] && action_t'(action) == ACT_CPU_RD) begin
          res.target     = TGT_PRG_ROM;
          res.mem_offset = {bank_m[3:0], addr[13:0]};
        end
      end
      ACT_PPU_RD: begin
        if (in_chr) begin
          if (cfg.chr_rom_size != '0) begin
            res.target     = TGT_CHR_ROM;
            res.mem_offset = chr_raw & chr_rom_mask;
          end else if (cfg.chr_ram_size != '0) begin
            res.target     = TGT_CHR_RAM;
            res.mem_offset = chr_raw & chr_ram_mask;
          end
        end
      end
      ACT_PPU_WR: begin
        if (in_chr && cfg.chr_ram_size != '0) begin
          res.target     = TGT_CHR_RAM;
          res.mem_offset = chr_raw & chr_ram_mask;
          res.mem_write  = 1'b1;
        end
      end
      default: ;
    endcase
    res.store_data = res.mem_write ? write_data : '0;
  end

endmodule

`default_nettype wire

FILE: rtl/serial_bank_switch_mapper.sv
// Top level of the serial bank switch mapper: input and result registers,
// configuration port, serial loader and address mapping.
// Depends on sbsm_pkg, sbsm_if, sbsm_cfg, sbsm_serial and sbsm_map.
//
//   channel   | dir | handshake          | beat contents
//   ----------+-----+--------------------+---------------------------------------------
//   in_bus    | in  | valid/ready        | action, addr, write_data
//   out_bus   | out | valid/ready        | target, mem_offset, mem_write, store_data,
//             |     |                    | mirroring
//   apb       | in  | psel/penable/pready| paddr, pwdata (writes), prdata (reads)
//
// One beat in, one beat out; a beat can enter every cycle. Its result passes
// through the input register and then the result register before it is offered on out_bus.
// The input register and the result register form a two-deep pipeline, so a
// new beat is taken while a finished result still waits for the sink.
// Reset (rst, synchronous, active high) clears both valid flags, the loader and
// the bank registers, and loads the configuration defaults.
// A stalled sink holds the result register; the input register then fills and
// drops in_bus.ready until the result moves on.
`default_nettype none

module serial_bank_switch_mapper
  import sbsm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  sbsm_in_if.sink                 in_bus,
  sbsm_out_if.source              out_bus,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  // Input register
  logic                s1_valid;
  logic [ACTION_W-1:0] s1_action;
  logic [ADDR_W-1:0]   s1_addr;
  logic [DATA_W-1:0]   s1_data;

  logic        advance;
  logic        load_in;
  logic        reg_strobe;
  cfg_t        cfg;
  bank_state_t st;
  logic [LOAD_W-1:0] control_next;
  map_result_t res;

  // Move the held beat on whenever the result register is empty or draining
  assign advance      = s1_valid && (!out_bus.valid || out_bus.ready);
  assign in_bus.ready = !s1_valid || advance;
  assign load_in      = in_bus.valid && in_bus.ready;

  // A CPU write into the upper half feeds the serial loader
  assign reg_strobe = advance && action_t'(s1_action) == ACT_CPU_WR && s1_addr[15];

  sbsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbsm_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .strobe       (reg_strobe),
    .sel          (s1_addr[14:13]),
    .data         (s1_data),
    .st           (st),
    .control_next (control_next)
  );

  sbsm_map u_map (
    .action     (s1_action),
    .addr       (s1_addr),
    .write_data (s1_data),
    .cfg        (cfg),
    .st         (st),
    .res        (res)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_bus.valid <= 1'b0;
    end else begin
      if (load_in)
        s1_valid <= 1'b1;
      else if (advance)
        s1_valid <= 1'b0;
      if (advance)
        out_bus.valid <= 1'b1;
      else if (out_bus.ready)
        out_bus.valid <= 1'b0;
    end
  end

  // Payload: capture the beat, then the mapped result with this beat's mirroring
  always_ff @(posedge clk) begin
    if (load_in) begin
      s1_action <= in_bus.action;
      s1_addr   <= in_bus.addr;
      s1_data   <= in_bus.write_data;
    end
    if (advance) begin
      out_bus.target     <= res.target;
      out_bus.mem_offset <= res.mem_offset;
      out_bus.mem_write  <= res.mem_write;
      out_bus.store_data <= res.store_data;
      out_bus.mirroring  <= control_next[MIRROR_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_write_target: assert property (@(posedge clk) disable iff (rst)
    out_bus.valid && out_bus.mem_write |->
      out_bus.target == TGT_PRG_RAM || out_bus.target == TGT_CHR_RAM)
    else $error("write strobe on a read-only or absent target");
  a_none_quiet: assert property (@(posedge clk) disable iff (rst)
    out_bus.valid && out_bus.target == TGT_NONE |->
      out_bus.mem_offset == '0 && !out_bus.mem_write && out_bus.store_data == '0)
    else $error("unmapped access carries offset or data");
  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_addr) && $stable(s1_action))
    else $error("held beat lost or changed while the result stalled");
  a_strobe_no_target: assert property (@(posedge clk) disable iff (rst)
    reg_strobe |=> out_bus.valid && out_bus.target == TGT_NONE)
    else $error("register write mapped to a memory");
`endif

endmodule

`default_nettype wire
